@@ rtl/core/encoder_adaptive_pll_speed_observer_unit_assert.svh @@
// Assertion macros for the encoder speed observer.
// Included by the top level; no other dependencies.
`ifndef ENCODER_ADAPTIVE_PLL_SPEED_OBSERVER_UNIT_ASSERT_SVH
`define ENCODER_ADAPTIVE_PLL_SPEED_OBSERVER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i and held off during reset.
`define EAPSO_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eapso assertion failed");
// Next-cycle implication, sampled on clk_i and held off during reset.
`define EAPSO_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("eapso assertion failed");
`else
`define EAPSO_ASSERT_IMP(name, ante, cons)
`define EAPSO_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ rtl/core/eapso_pkg.sv @@
// Shared types and constants of the encoder speed observer.
// No dependencies; imported by every module of the block.
`default_nettype none

package eapso_pkg;

  // Default raw counter width.
  localparam int unsigned CounterBitsDefault = 16;

  // Configuration port and result widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SpeedW   = 28;
  localparam int unsigned PosW     = 32;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegErrLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegErrHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWnLow   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWnHigh  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlope   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegZeta2   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDt      = 3'd6;

  // Register reset values.
  localparam logic [21:0] ErrLowReset  = 22'd179;
  localparam logic [21:0] ErrHighReset = 22'd1280;
  localparam logic [19:0] WnLowReset   = 20'd3217;
  localparam logic [19:0] WnHighReset  = 20'd33779;
  localparam logic [31:0] SlopeReset   = 32'd1819400;
  localparam logic [20:0] Zeta2Reset   = 21'd157286;
  localparam logic [31:0] DtReset      = 32'd21474836;

  // Observer limits.
  localparam logic signed [40:0] ErrLim        = 41'sd2560000;
  localparam logic signed [27:0] OmegaLim      = 28'sd128000000;
  localparam logic signed [31:0] ThetaRecentre = 32'sd5120000;
  localparam logic [19:0]        WnMax         = 20'hFFFFF;

  // Configuration register set.
  typedef struct packed {
    logic [21:0] err_low;
    logic [21:0] err_high;
    logic [19:0] wn_low;
    logic [19:0] wn_high;
    logic [31:0] slope;
    logic [20:0] zeta2;
    logic [31:0] dt;
  } cfg_t;

  // Datapath commands, in the order the sequencer issues them.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_EXT,
    CMD_ERR,
    CMD_WN_MUL,
    CMD_WN,
    CMD_KI_MUL,
    CMD_KP_MUL,
    CMD_KIE_LO,
    CMD_KIE_HI,
    CMD_KIE_SUM,
    CMD_OM_LO,
    CMD_OM_HI,
    CMD_OM_SUM,
    CMD_OM_UPD,
    CMD_P_LO,
    CMD_P_HI,
    CMD_P_SUM,
    CMD_S,
    CMD_T_LO,
    CMD_T_HI,
    CMD_T_SUM,
    CMD_TH,
    CMD_RC,
    CMD_OUT
  } cmd_e;

endpackage

`default_nettype wire

@@ rtl/core/eapso_regs.sv @@
// Configuration register file of the encoder speed observer.
// Depends on eapso_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module eapso_regs
  import eapso_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; an unknown index leaves the set unchanged.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegErrLow:  cfg_d.err_low  = cfg_data_i[21:0];
        RegErrHigh: cfg_d.err_high = cfg_data_i[21:0];
        RegWnLow:   cfg_d.wn_low   = cfg_data_i[19:0];
        RegWnHigh:  cfg_d.wn_high  = cfg_data_i[19:0];
        RegSlope:   cfg_d.slope    = cfg_data_i;
        RegZeta2:   cfg_d.zeta2    = cfg_data_i[20:0];
        RegDt:      cfg_d.dt       = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.err_low  <= ErrLowReset;
      cfg_q.err_high <= ErrHighReset;
      cfg_q.wn_low   <= WnLowReset;
      cfg_q.wn_high  <= WnHighReset;
      cfg_q.slope    <= SlopeReset;
      cfg_q.zeta2    <= Zeta2Reset;
      cfg_q.dt       <= DtReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/eapso_dp.sv @@
// Datapath of the encoder speed observer: count extension, PLL state and
// one shared 32x32 multiplier. Depends on eapso_pkg for cmd_e and cfg_t.
`default_nettype none

module eapso_dp
  import eapso_pkg::*;
#(
  parameter int unsigned CounterBits = CounterBitsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_e                     cmd_i,
  input  wire cfg_t                     cfg_i,
  input  wire logic [CounterBits-1:0]   raw_i,
  output logic signed [SpeedW-1:0]      speed_o,
  output logic [PosW-1:0]               position_o
);

  typedef enum logic [1:0] {
    WN_LOW,
    WN_HIGH,
    WN_INTERP
  } wn_sel_e;

  localparam logic signed [31:0] ThMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ThMin = 32'sh8000_0000;

  // Observer state.
  logic                     started_q, started_d;
  logic [CounterBits-1:0]   prev_q, prev_d;
  logic [31:0]              ext_q, ext_d;
  logic [31:0]              off_q, off_d;
  logic signed [31:0]       theta_q, theta_d;
  logic signed [SpeedW-1:0] omega_q, omega_d;

  // Per-sample working registers.
  logic [21:0]  aerr_q, aerr_d;
  logic         eneg_q, eneg_d;
  wn_sel_e      wn_sel_q, wn_sel_d;
  logic [19:0]  wn_q, wn_d;
  logic [39:0]  ki_q, ki_d;
  logic [40:0]  kp_q, kp_d;
  logic [63:0]  prod_q, prod_d;
  logic [63:0]  lo_q, lo_d;
  logic [95:0]  wide_q, wide_d;
  logic [47:0]  as_q, as_d;
  logic         sneg_q, sneg_d;

  // Result register.
  logic signed [SpeedW-1:0] speed_q, speed_d;
  logic [PosW-1:0]          pos_q, pos_d;

  // Shared multiplier.
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  // Intermediate values.
  logic [CounterBits-1:0]        diff_w;
  logic signed [CounterBits-1:0] diff_s;
  logic [31:0]                   step_w;
  logic [31:0]                   local_w;
  logic signed [40:0]            err_w, err_c, err_mag;
  logic [21:0]                   wn_diff;
  logic [48:0]                   wn_sum;
  logic [47:0]                   oinc;
  logic signed [49:0]            oinc_s, om_sum;
  logic signed [SpeedW-1:0]      om_sat;
  logic signed [49:0]            p_s, s_w, s_mag;
  logic [55:0]                   tinc;
  logic signed [57:0]            tinc_s, th_sum;
  logic signed [31:0]            th_sat;
  logic                          rc_hit, rc_neg;
  logic [32:0]                   rc_mag;
  logic [24:0]                   rc_shift;
  logic [7:0]                    rc_rem;
  logic [95:0]                   wide_sum;

  // Signed counter difference, extended to the 32-bit count.
  assign diff_w = raw_i - prev_q;
  assign diff_s = $signed(diff_w);
  assign step_w = 32'(diff_s);

  // Position error in Q.8, clamped, split into magnitude and sign.
  assign local_w = ext_q - off_q;
  assign err_w   = $signed({local_w[31], local_w, 8'h00}) - 41'(theta_q);

  always_comb begin
    if (err_w > ErrLim) begin
      err_c = ErrLim;
    end else if (err_w < -ErrLim) begin
      err_c = -ErrLim;
    end else begin
      err_c = err_w;
    end
    err_mag = err_c[40] ? -err_c : err_c;
  end

  // Natural frequency interpolation, saturated to 20 bits.
  assign wn_diff = aerr_q - cfg_i.err_low;
  assign wn_sum  = 49'(cfg_i.wn_low) + 49'(prod_q[63:16]);

  // Speed update from the integral path.
  assign oinc   = wide_q[95:48];
  assign oinc_s = $signed({2'b00, oinc});
  assign om_sum = 50'(omega_q) + (eneg_q ? -oinc_s : oinc_s);

  always_comb begin
    if (om_sum > 50'(OmegaLim)) begin
      om_sat = OmegaLim;
    end else if (om_sum < -50'(OmegaLim)) begin
      om_sat = -OmegaLim;
    end else begin
      om_sat = om_sum[SpeedW-1:0];
    end
  end

  // Slope term: speed plus the proportional correction.
  assign p_s   = $signed({2'b00, wide_q[63:16]});
  assign s_w   = $signed({{14{omega_q[SpeedW-1]}}, omega_q, 8'h00}) + (eneg_q ? -p_s : p_s);
  assign s_mag = s_w[49] ? -s_w : s_w;

  // Position estimate update, saturated to 32 bits.
  assign tinc   = wide_q[95:40];
  assign tinc_s = $signed({2'b00, tinc});
  assign th_sum = 58'(theta_q) + (sneg_q ? -tinc_s : tinc_s);

  always_comb begin
    if (th_sum > 58'(ThMax)) begin
      th_sat = ThMax;
    end else if (th_sum < 58'(ThMin)) begin
      th_sat = ThMin;
    end else begin
      th_sat = th_sum[31:0];
    end
  end

  // Re-centring moves the whole counts of theta into the frame offset.
  assign rc_hit   = (theta_q > ThetaRecentre) || (theta_q < -ThetaRecentre);
  assign rc_neg   = theta_q[31];
  assign rc_mag   = rc_neg ? -33'(theta_q) : 33'(theta_q);
  assign rc_shift = rc_mag[32:8];
  assign rc_rem   = rc_mag[7:0];

  // Joins the low and high partial products of a 64x32 product.
  assign wide_sum = {prod_q + {32'h0, lo_q[63:32]}, lo_q[31:0]};

  // Multiplier operand selection per command.
  always_comb begin
    case (cmd_i)
      CMD_WN_MUL: begin
        mul_x = 32'(wn_diff);
        mul_y = cfg_i.slope;
      end
      CMD_KI_MUL: begin
        mul_x = 32'(wn_q);
        mul_y = 32'(wn_q);
      end
      CMD_KP_MUL: begin
        mul_x = 32'(cfg_i.zeta2);
        mul_y = 32'(wn_q);
      end
      CMD_KIE_LO: begin
        mul_x = ki_q[31:0];
        mul_y = 32'(aerr_q);
      end
      CMD_KIE_HI: begin
        mul_x = 32'(ki_q[39:32]);
        mul_y = 32'(aerr_q);
      end
      CMD_OM_LO: begin
        mul_x = wide_q[31:0];
        mul_y = cfg_i.dt;
      end
      CMD_OM_HI: begin
        mul_x = wide_q[63:32];
        mul_y = cfg_i.dt;
      end
      CMD_P_LO: begin
        mul_x = kp_q[31:0];
        mul_y = 32'(aerr_q);
      end
      CMD_P_HI: begin
        mul_x = 32'(kp_q[40:32]);
        mul_y = 32'(aerr_q);
      end
      CMD_T_LO: begin
        mul_x = as_q[31:0];
        mul_y = cfg_i.dt;
      end
      CMD_T_HI: begin
        mul_x = 32'(as_q[47:32]);
        mul_y = cfg_i.dt;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  // Next-state logic, one step per command.
  always_comb begin
    started_d = started_q;
    prev_d    = prev_q;
    ext_d     = ext_q;
    off_d     = off_q;
    theta_d   = theta_q;
    omega_d   = omega_q;
    aerr_d    = aerr_q;
    eneg_d    = eneg_q;
    wn_sel_d  = wn_sel_q;
    wn_d      = wn_q;
    ki_d      = ki_q;
    kp_d      = kp_q;
    prod_d    = prod_q;
    lo_d      = lo_q;
    wide_d    = wide_q;
    as_d      = as_q;
    sneg_d    = sneg_q;
    speed_d   = speed_q;
    pos_d     = pos_q;
    case (cmd_i)
      CMD_EXT: begin
        prev_d    = raw_i;
        started_d = 1'b1;
        ext_d     = started_q ? ext_q + step_w : '0;
      end
      CMD_ERR: begin
        aerr_d = err_mag[21:0];
        eneg_d = err_c[40];
      end
      CMD_WN_MUL: begin
        prod_d = mul_p;
        if (aerr_q <= cfg_i.err_low) begin
          wn_sel_d = WN_LOW;
        end else if (aerr_q >= cfg_i.err_high) begin
          wn_sel_d = WN_HIGH;
        end else begin
          wn_sel_d = WN_INTERP;
        end
      end
      CMD_WN: begin
        case (wn_sel_q)
          WN_LOW:    wn_d = cfg_i.wn_low;
          WN_HIGH:   wn_d = cfg_i.wn_high;
          WN_INTERP: wn_d = (wn_sum > 49'(WnMax)) ? WnMax : wn_sum[19:0];
          default:   wn_d = cfg_i.wn_low;
        endcase
      end
      CMD_KI_MUL, CMD_OM_LO, CMD_P_LO, CMD_T_LO: begin
        prod_d = mul_p;
      end
      CMD_KP_MUL: begin
        ki_d   = prod_q[39:0];
        prod_d = mul_p;
      end
      CMD_KIE_LO: begin
        kp_d   = prod_q[40:0];
        prod_d = mul_p;
      end
      CMD_KIE_HI, CMD_OM_HI, CMD_P_HI, CMD_T_HI: begin
        lo_d   = prod_q;
        prod_d = mul_p;
      end
      CMD_KIE_SUM, CMD_OM_SUM, CMD_P_SUM, CMD_T_SUM: begin
        wide_d = wide_sum;
      end
      CMD_OM_UPD: begin
        omega_d = om_sat;
      end
      CMD_S: begin
        as_d   = s_mag[47:0];
        sneg_d = s_w[49];
      end
      CMD_TH: begin
        theta_d = th_sat;
      end
      CMD_RC: begin
        if (rc_hit) begin
          off_d   = rc_neg ? off_q - 32'(rc_shift) : off_q + 32'(rc_shift);
          theta_d = rc_neg ? -$signed({24'h0, rc_rem}) : $signed({24'h0, rc_rem});
        end
      end
      CMD_OUT: begin
        speed_d = omega_q;
        pos_d   = ext_q;
      end
      default: ;
    endcase
  end

  // Observer state is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      prev_q    <= '0;
      ext_q     <= '0;
      off_q     <= '0;
      theta_q   <= '0;
      omega_q   <= '0;
    end else begin
      started_q <= started_d;
      prev_q    <= prev_d;
      ext_q     <= ext_d;
      off_q     <= off_d;
      theta_q   <= theta_d;
      omega_q   <= omega_d;
    end
  end

  // Working and result registers carry payload only.
  always_ff @(posedge clk_i) begin
    aerr_q   <= aerr_d;
    eneg_q   <= eneg_d;
    wn_sel_q <= wn_sel_d;
    wn_q     <= wn_d;
    ki_q     <= ki_d;
    kp_q     <= kp_d;
    prod_q   <= prod_d;
    lo_q     <= lo_d;
    wide_q   <= wide_d;
    as_q     <= as_d;
    sneg_q   <= sneg_d;
    speed_q  <= speed_d;
    pos_q    <= pos_d;
  end

  assign speed_o    = speed_q;
  assign position_o = pos_q;

endmodule

`default_nettype wire

@@ rtl/core/eapso_ctrl.sv @@
// Sequencer of the encoder speed observer: handshakes and command order.
// Depends on eapso_pkg for cmd_e.
`default_nettype none

module eapso_ctrl
  import eapso_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_e      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  cmd_e   step_q, step_d;
  logic   out_valid_q, out_valid_d;

  // Walk the command list once per sample, then load the result register.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = CMD_NONE;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_EXT;
          step_d  = CMD_ERR;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o = step_q;
        if (step_q == CMD_RC) begin
          state_d = ST_OUT;
        end else begin
          step_d = cmd_e'(step_q + 5'd1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= CMD_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/encoder_adaptive_pll_speed_observer_unit.sv @@
// Encoder speed observer with an adaptive-bandwidth PLL. One raw counter
// sample is taken per transaction on the slave stream and one result (speed
// in counts/s Q.8 and the extended 32-bit count) is given per sample on the
// master stream. From acceptance to the result register, the count is
// extended, twenty-one steps run the error, gain and state updates through
// a single shared 32x32 multiplier, and the result is loaded. The next
// sample is accepted as soon as the sequencer is back in idle, even while
// the previous result still waits; a finished result waits for the
// register only if the one before it has not yet been taken. Configuration
// writes are always taken and should be made while no sample is in flight.
//
// Depends on eapso_pkg, eapso_regs, eapso_dp, eapso_ctrl and the assertion
// header.
`default_nettype none

`include "encoder_adaptive_pll_speed_observer_unit_assert.svh"

module encoder_adaptive_pll_speed_observer_unit
  import eapso_pkg::*;
#(
  parameter int unsigned CounterBits = CounterBitsDefault,
  localparam int unsigned InDataW  = ((CounterBits + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((SpeedW + PosW + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Sample stream.
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,  // raw_count
  // Result stream.
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,  // speed_q8, position_count
  // Configuration write channel.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t                     cfg;
  cmd_e                     cmd;
  logic signed [SpeedW-1:0] speed;
  logic [PosW-1:0]          position;

  // Configuration registers.
  eapso_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  eapso_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // Datapath.
  eapso_dp #(
    .CounterBits (CounterBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .raw_i      (s_axis_tdata_i[CounterBits-1:0]),
    .speed_o    (speed),
    .position_o (position)
  );

  // Result packing: speed in the low bits, then the extended count.
  assign m_axis_tdata_o = OutDataW'({position, speed});

  // An accepted sample extends the count at once; the error step follows in the next cycle.
  `EAPSO_ASSERT_NXT(a_accept_starts_run, s_axis_tvalid_i && s_axis_tready_o, cmd == CMD_ERR)
  // Loading the result register raises the output valid.
  `EAPSO_ASSERT_NXT(a_load_sets_valid, cmd == CMD_OUT, m_axis_tvalid_o)
  // A presented speed always lies inside the saturation band.
  `EAPSO_ASSERT_IMP(a_speed_in_band, m_axis_tvalid_o,
    (speed <= OmegaLim) && (speed >= -OmegaLim))

endmodule

`default_nettype wire
